// ===== rtl/krt_pkg.sv =====
// Shared command and status codes and the record type for the keyed record table.
package krt_pkg;
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_FIND   = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int REC_W = 24 + 64 + 5 * 64 + 32 + 5 + 4;

	typedef struct packed {
		logic [23:0] kh;
		logic [63:0] kl;
		logic [63:0] n0;
		logic [63:0] n1;
		logic [63:0] n2;
		logic [63:0] n3;
		logic [63:0] n4;
		logic [31:0] n5;
		logic [4:0]  day;
		logic [3:0]  month;
	} rec_t;
endpackage

// ===== rtl/keyed_record_table.sv =====
// Keyed record table: top level with record memory and command sequencer.
//
// The table holds up to CAPACITY records in one synchronous memory (one read
// port, one write port, registered read), slot count-1 being the newest.
// Add, clear and every command that finds the table empty or full give their
// result in the cycle after the item is taken, and the next item can be taken
// as that result leaves. Find scans keys from the newest slot down, each key
// examined by a read (S_SCAN) and then the compare (S_CMP); a hit goes through
// S_FOUND into the output register, a miss is loaded from S_CMP at slot 0.
// Remove does the same scan and then closes the gap by copying each younger
// record one slot down, a read (S_MOVRD) and a write (S_MOVWR) per record
// moved. List reads each record, newest first, and emits each one; each
// result waits in the output register until taken, which holds the walk. One
// command is worked on at a time; stall is high while a command is running.
module keyed_record_table
	import krt_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int KEY_CHARS  = 11,
	parameter int NAME_CHARS = 44
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [23:0] key_high,
	input  logic [63:0] key_low,
	input  logic [63:0] name_word_0,
	input  logic [63:0] name_word_1,
	input  logic [63:0] name_word_2,
	input  logic [63:0] name_word_3,
	input  logic [63:0] name_word_4,
	input  logic [31:0] name_word_5,
	input  logic [4:0]  birth_day,
	input  logic [3:0]  birth_month,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        last_of_run,
	output logic [23:0] rec_key_high,
	output logic [63:0] rec_key_low,
	output logic [63:0] rec_name_0,
	output logic [63:0] rec_name_1,
	output logic [63:0] rec_name_2,
	output logic [63:0] rec_name_3,
	output logic [63:0] rec_name_4,
	output logic [31:0] rec_name_5,
	output logic [4:0]  rec_day,
	output logic [3:0]  rec_month
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_MOVRD = 3'd3;
	localparam logic [2:0] S_MOVWR = 3'd4;
	localparam logic [2:0] S_LIST  = 3'd5;
	localparam logic [2:0] S_LOUT  = 3'd6;
	localparam logic [2:0] S_FOUND = 3'd7;

	// Character masks for the configured key and name lengths.
	function automatic logic [87:0] key_mask();
		logic [87:0] m;
		m = '0;
		for (int i = 0; i < 11; i++)
			if (i < KEY_CHARS) m[87 - 8 * i -: 8] = 8'hFF;
		return m;
	endfunction
	function automatic logic [351:0] name_mask();
		logic [351:0] m;
		m = '0;
		for (int i = 0; i < 44; i++)
			if (i < NAME_CHARS) m[351 - 8 * i -: 8] = 8'hFF;
		return m;
	endfunction

	rec_t mem [CAPACITY];
	rec_t rd_q;
	rec_t wr_d;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_d;
		rd_q <= mem[rd_addr];
	end

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;     // slot being read; scans use idx_q-1 style counts
	logic [2:0]    cmd_q;
	logic [87:0]   key_q;
	logic          ovalid_q;
	logic [1:0]    ostat_q;
	logic          olast_q;
	rec_t          orec_q;

	logic [87:0] key_in;
	logic [351:0] name_in;
	assign key_in  = {key_high, key_low} & key_mask();
	assign name_in = {name_word_0, name_word_1, name_word_2, name_word_3,
		name_word_4, name_word_5} & name_mask();

	logic out_free;
	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	logic accept;
	assign accept = in_valid && !in_stall;

	logic match;
	assign match = ({rd_q.kh, rd_q.kl} == key_q);

	// High when a result item is loaded into the output register this cycle.
	logic out_load;
	always_comb begin
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept)
					out_load = (command == CMD_ADD) || (command == CMD_CLEAR) ||
						((command inside {CMD_FIND, CMD_REMOVE, CMD_LIST}) &&
						(count_q == '0));
			end
			S_CMP: out_load = !match && (idx_q == '0) && out_free;
			S_FOUND, S_LOUT: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_d    = {key_in[87:64], key_in[63:0], name_in, birth_day, birth_month};
		rd_addr = idx_q[AW-1:0];
		if (state_q == S_IDLE && accept && command == CMD_ADD && count_q < CW'(CAPACITY))
			wr_en = 1'b1;
		if (state_q == S_MOVWR) begin
			wr_en   = 1'b1;
			wr_addr = AW'(idx_q - 1'b1);
			wr_d    = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			cmd_q    <= CMD_ADD;
			key_q    <= '0;
			ovalid_q <= 1'b0;
			ostat_q  <= ST_OK;
			olast_q  <= 1'b0;
			orec_q   <= '0;
		end else begin
			ovalid_q <= out_load || (ovalid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						key_q <= key_in;
						orec_q <= '0;
						olast_q <= 1'b1;
						case (command)
							CMD_ADD: begin
								if (count_q >= CW'(CAPACITY)) ostat_q <= ST_FULL;
								else begin
									ostat_q <= ST_OK;
									count_q <= count_q + 1'b1;
								end
							end
							CMD_CLEAR: begin
								ostat_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
								count_q <= '0;
							end
							CMD_FIND, CMD_REMOVE, CMD_LIST: begin
								if (count_q == '0) begin
									ostat_q <= ST_EMPTY;
								end else begin
									idx_q <= count_q - 1'b1;
									state_q <= (command == CMD_LIST) ? S_LIST : S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: state_q <= S_CMP;   // read of slot idx_q in flight
				S_CMP: begin
					if (match) state_q <= S_FOUND;
					else if (idx_q == '0) begin
						if (out_free) begin
							ostat_q <= ST_NOTFOUND;
							olast_q <= 1'b1;
							orec_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_FOUND: begin
					if (out_free) begin
						ostat_q <= ST_OK;
						olast_q <= 1'b1;
						orec_q <= rd_q;
						if (cmd_q == CMD_REMOVE) begin
							if (idx_q + 1'b1 >= count_q) begin
								count_q <= count_q - 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_MOVRD;
							end
						end else state_q <= S_IDLE;
					end
				end
				S_MOVRD: state_q <= S_MOVWR;
				S_MOVWR: begin
					// rd_q holds slot idx_q, written to idx_q-1 this cycle.
					if (idx_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_MOVRD;
					end
				end
				S_LIST: state_q <= S_LOUT;
				S_LOUT: begin
					if (out_free) begin
						ostat_q <= ST_OK;
						orec_q <= rd_q;
						olast_q <= (idx_q == '0);
						if (idx_q == '0) state_q <= S_IDLE;
						else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_LIST;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = ostat_q;
	assign last_of_run  = olast_q;
	assign rec_key_high = orec_q.kh;
	assign rec_key_low  = orec_q.kl;
	assign rec_name_0   = orec_q.n0;
	assign rec_name_1   = orec_q.n1;
	assign rec_name_2   = orec_q.n2;
	assign rec_name_3   = orec_q.n3;
	assign rec_name_4   = orec_q.n4;
	assign rec_name_5   = orec_q.n5;
	assign rec_day      = orec_q.day;
	assign rec_month    = orec_q.month;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the keyed record table, checked against a copy of the table.
module testbench;
	import krt_pkg::*;

	localparam int CAP = 16;

	// One expected or observed result item.
	typedef struct packed {
		logic [1:0] st;
		logic       last;
		rec_t       rec;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = CMD_ADD;
	logic [23:0] key_high = '0;
	logic [63:0] key_low = '0;
	logic [63:0] name_word_0 = '0, name_word_1 = '0, name_word_2 = '0;
	logic [63:0] name_word_3 = '0, name_word_4 = '0;
	logic [31:0] name_word_5 = '0;
	logic [4:0]  birth_day = '0;
	logic [3:0]  birth_month = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [1:0]  status;
	logic        last_of_run;
	logic [23:0] rec_key_high;
	logic [63:0] rec_key_low, rec_name_0, rec_name_1, rec_name_2, rec_name_3, rec_name_4;
	logic [31:0] rec_name_5;
	logic [4:0]  rec_day;
	logic [3:0]  rec_month;

	keyed_record_table dut (.*);

	// The clock runs with a period of four units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Software copy of the table: slot count-1 holds the newest record.
	rec_t    table_rows[CAP];
	int      row_count = 0;
	result_t pending_results[$];
	int      mismatches = 0;
	bit      hold_receiver = 1'b0;
	bit      receiver_idle = 1'b1;

	// Computes the results of one command and updates the table copy.
	task automatic predict_command(input logic [2:0] cmd, input rec_t r);
		result_t res;
		int      hit;
		hit = -1;
		res = '0;
		res.last = 1'b1;
		case (cmd)
			CMD_ADD: begin
				if (row_count >= CAP) begin
					res.st = ST_FULL;
				end else begin
					table_rows[row_count] = r;
					row_count++;
					res.st = ST_OK;
				end
				pending_results.push_back(res);
			end
			CMD_FIND, CMD_REMOVE: begin
				// The newest record whose whole key matches wins.
				for (int i = row_count - 1; i >= 0 && hit < 0; i--)
					if (table_rows[i].kh == r.kh && table_rows[i].kl == r.kl)
						hit = i;
				if (row_count == 0) begin
					res.st = ST_EMPTY;
				end else if (hit < 0) begin
					res.st = ST_NOTFOUND;
				end else begin
					res.st = ST_OK;
					res.rec = table_rows[hit];
					if (cmd == CMD_REMOVE) begin
						for (int i = hit; i + 1 < row_count; i++)
							table_rows[i] = table_rows[i + 1];
						row_count--;
					end
				end
				pending_results.push_back(res);
			end
			CMD_CLEAR: begin
				res.st = (row_count == 0) ? ST_EMPTY : ST_OK;
				row_count = 0;
				pending_results.push_back(res);
			end
			CMD_LIST: begin
				if (row_count == 0) begin
					res.st = ST_EMPTY;
					pending_results.push_back(res);
				end else begin
					for (int i = row_count - 1; i >= 0; i--) begin
						res.st = ST_OK;
						res.rec = table_rows[i];
						res.last = (i == 0);
						pending_results.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offers one item after a random gap, or none when no_gap is set, and waits until it is accepted.
	task automatic send_command(input logic [2:0] cmd, input rec_t r, input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key_high <= r.kh;
		key_low <= r.kl;
		name_word_0 <= r.n0;
		name_word_1 <= r.n1;
		name_word_2 <= r.n2;
		name_word_3 <= r.n3;
		name_word_4 <= r.n4;
		name_word_5 <= r.n5;
		birth_day <= r.day;
		birth_month <= r.month;
		do @(posedge clk); while (in_stall);
		predict_command(cmd, r);
	endtask

	// Random record; most keys come from a small pool so that matches and duplicates are common.
	function automatic rec_t random_record();
		rec_t r;
		r.kh = 24'($urandom);
		r.kl = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0) begin
			r.kh = 24'h4B0000 | 24'($urandom_range(0, 3));
			r.kl = 64'($urandom_range(0, 1)) << 56;
		end
		r.n0 = {$urandom, $urandom};
		r.n1 = {$urandom, $urandom};
		r.n2 = {$urandom, $urandom};
		r.n3 = {$urandom, $urandom};
		r.n4 = {$urandom, $urandom};
		r.n5 = $urandom;
		r.day = 5'($urandom);
		r.month = 4'($urandom);
		return r;
	endfunction

	// The receiver stalls at random, or for a long stretch when asked to.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (hold_receiver) begin
				out_stall <= 1'b1;
				receiver_idle = 1'b0;
				repeat (300) @(posedge clk);
				hold_receiver = 1'b0;
			end
			wait_cycles = receiver_idle ? 0 : $urandom_range(0, 13);
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, last_of_run, rec_key_high, rec_key_low, rec_name_0, rec_name_1,
				rec_name_2, rec_name_3, rec_name_4, rec_name_5, rec_day, rec_month};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	// Empty-table cases, clear, single add, find hit and miss, remove and list.
	task automatic test_basic_commands();
		rec_t r;
		r = random_record();
		send_command(CMD_FIND, r);
		send_command(CMD_REMOVE, r);
		send_command(CMD_CLEAR, r);
		send_command(CMD_LIST, r);
		send_command(CMD_ADD, r);
		send_command(CMD_FIND, r);
		send_command(CMD_LIST, r);
		r.kl = ~r.kl;
		send_command(CMD_FIND, r);
		r.kl = ~r.kl;
		send_command(CMD_REMOVE, r);
		send_command(CMD_REMOVE, r);
	endtask

	// Extreme field values, bytes after a zero byte, duplicates, a full table and unknown command codes.
	task automatic test_extremes_and_full();
		rec_t r;
		r = '1;
		send_command(CMD_ADD, r);
		r = '0;
		send_command(CMD_ADD, r);
		send_command(CMD_FIND, r);
		r.kh = 24'h410042;
		send_command(CMD_ADD, r);
		send_command(CMD_FIND, r);
		for (int i = 0; i < CAP; i++)
			send_command(CMD_ADD, random_record());
		send_command(CMD_LIST, r);
		send_command(3'd5, r);
		send_command(3'd7, r);
		send_command(CMD_CLEAR, r);
	endtask

	// The receiver holds off while commands keep coming, so the output register stays full and the input stalls.
	task automatic test_output_backpressure();
		hold_receiver = 1'b1;
		receiver_idle = 1'b0;
		for (int i = 0; i < 6; i++)
			send_command(CMD_ADD, random_record(), 1);
		send_command(CMD_LIST, random_record(), 1);
		send_command(CMD_FIND, random_record(), 1);
	endtask

	// Random command mix weighted toward adds so the table often fills.
	task automatic test_random_commands();
		int pick;
		logic [2:0] cmd;
		for (int i = 0; i < 480; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) cmd = CMD_ADD;
			else if (pick < 60) cmd = CMD_FIND;
			else if (pick < 78) cmd = CMD_REMOVE;
			else if (pick < 83) cmd = CMD_CLEAR;
			else if (pick < 97) cmd = CMD_LIST;
			else cmd = 3'($urandom_range(5, 7));
			send_command(cmd, random_record());
		end
	endtask

	initial begin
		int drain;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		receiver_idle = 1'b0;
		test_basic_commands();
		test_extremes_and_full();
		test_output_backpressure();
		test_random_commands();
		in_valid <= 1'b0;
		drain = 0;
		while (pending_results.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("keyed_record_table test passed");
		else
			$display("keyed_record_table test failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("keyed_record_table test failed");
		$finish;
	end
endmodule
